### src/mlin_pkg.sv
// ============================================================================
// mlin_pkg
// shared types, latencies, register codes and saturating helpers for the
// level-1 mosfet linearizer
// ============================================================================
package mlin_pkg;

   localparam int DW         = 64;
   localparam int SQRT_STEPS = 64;
   localparam int DIV_STEPS  = 64;
   localparam int BODY_LAT   = SQRT_STEPS + DIV_STEPS + 2;
   localparam int QMUL_LAT   = 4;

   // csr register indexes
   localparam logic [2:0] REG_VT0    = 3'd0;
   localparam logic [2:0] REG_GAMMA  = 3'd1;
   localparam logic [2:0] REG_PHI    = 3'd2;
   localparam logic [2:0] REG_KP     = 3'd3;
   localparam logic [2:0] REG_LAMBDA = 3'd4;

   typedef logic signed [DW-1:0] word_type;

   localparam word_type SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type SMIN = {1'b1, {(DW-1){1'b0}}};

   function automatic word_type sat_add(word_type a, word_type b);
      word_type s;
      s = a + b;
      if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1]) s = a[DW-1] ? SMIN : SMAX;
      return s;
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      word_type s;
      s = a - b;
      if (a[DW-1] != b[DW-1] && s[DW-1] != a[DW-1]) s = a[DW-1] ? SMIN : SMAX;
      return s;
   endfunction

   function automatic word_type sat_neg(word_type a);
      return (a == SMIN) ? SMAX : -a;
   endfunction

   // magnitude clipped to the positive range
   function automatic word_type mag_sat(word_type a);
      return a[DW-1] ? sat_neg(a) : a;
   endfunction

   // halving that truncates toward zero
   function automatic word_type half(word_type a);
      word_type s;
      s = a + word_type'({{(DW-1){1'b0}}, a[DW-1]});
      return s >>> 1;
   endfunction

endpackage

### src/mlin_qmul.sv
// ============================================================================
// mlin_qmul
// pipelined saturating fixed-point multiply, four 32x32 partial products,
// magnitude truncated toward zero
// ============================================================================
module mlin_qmul #(
   parameter int FRAC_BITS = 48
) (
   input  logic               clock,
   input  mlin_pkg::word_type a,
   input  mlin_pkg::word_type b,
   output mlin_pkg::word_type p
);

   logic [63:0]  ma_ff, mb_ff;
   logic         neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] full;
   logic [63:0]  m3_ff;
   logic         big3_ff;
   mlin_pkg::word_type p_ff;

   always_comb begin
      full = {64'd0, ll_ff} + ({64'd0, lh_ff} << 32) + ({64'd0, hl_ff} << 32)
           + {hh_ff, 64'd0};
   end

   always_ff @(posedge clock) begin
      ma_ff   <= a[63] ? -a : a;
      mb_ff   <= b[63] ? -b : b;
      neg1_ff <= a[63] ^ b[63];
      ll_ff   <= ma_ff[31:0]  * mb_ff[31:0];
      lh_ff   <= ma_ff[31:0]  * mb_ff[63:32];
      hl_ff   <= ma_ff[63:32] * mb_ff[31:0];
      hh_ff   <= ma_ff[63:32] * mb_ff[63:32];
      neg2_ff <= neg1_ff;
      m3_ff   <= full[FRAC_BITS +: 64];
      big3_ff <= |(full >> (FRAC_BITS + 64));
      neg3_ff <= neg2_ff;
      if (neg3_ff) begin
         p_ff <= (big3_ff || m3_ff[63]) ? mlin_pkg::SMIN : -m3_ff;
      end else begin
         p_ff <= (big3_ff || m3_ff[63]) ? mlin_pkg::SMAX : m3_ff;
      end
   end

   assign p = p_ff;

endmodule

### src/mlin_body.sv
// ============================================================================
// mlin_body
// body effect front end: two pipelined square roots (one result bit per
// stage) followed by a pipelined restoring divider (one quotient bit per stage)
// ============================================================================
module mlin_body #(
   parameter int FRAC_BITS = 48
) (
   input  logic               clock,
   input  logic [63:0]        rad_a,
   input  logic [63:0]        rad_b,
   input  logic [62:0]        gam,
   input  logic               neg,
   output mlin_pkg::word_type sa,
   output mlin_pkg::word_type s2,
   output mlin_pkg::word_type quot
);

   typedef struct packed {
      logic [127:0] rad_a;
      logic [127:0] rad_b;
      logic [66:0]  rem_a;
      logic [66:0]  rem_b;
      logic [63:0]  root_a;
      logic [63:0]  root_b;
      logic [62:0]  gam;
      logic         neg;
   } sq_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] lo;
      logic [63:0] q;
      logic [63:0] dvsr;
      logic [63:0] sa;
      logic [63:0] s2;
      logic        ovr;
      logic [63:0] ovr_val;
   } dv_type;

   sq_type sq_init;
   sq_type sq_ff [mlin_pkg::SQRT_STEPS];
   dv_type dv0_ff;
   dv_type dv_ff [mlin_pkg::DIV_STEPS];
   mlin_pkg::word_type sa_ff, s2_ff, q_ff;

   function automatic sq_type sq_step(sq_type s);
      sq_type      o;
      logic [66:0] ra, rb, ta, tb;
      o  = s;
      ra = {s.rem_a[64:0], s.rad_a[127:126]};
      rb = {s.rem_b[64:0], s.rad_b[127:126]};
      ta = {1'b0, s.root_a, 2'b01};
      tb = {1'b0, s.root_b, 2'b01};
      if (ra >= ta) begin
         o.rem_a  = ra - ta;
         o.root_a = {s.root_a[62:0], 1'b1};
      end else begin
         o.rem_a  = ra;
         o.root_a = {s.root_a[62:0], 1'b0};
      end
      if (rb >= tb) begin
         o.rem_b  = rb - tb;
         o.root_b = {s.root_b[62:0], 1'b1};
      end else begin
         o.rem_b  = rb;
         o.root_b = {s.root_b[62:0], 1'b0};
      end
      o.rad_a = s.rad_a << 2;
      o.rad_b = s.rad_b << 2;
      return o;
   endfunction

   function automatic dv_type dv_prep(sq_type s);
      dv_type      o;
      logic [63:0] ua;
      ua        = {1'b0, s.gam};
      o.sa      = s.root_a;
      o.s2      = s.root_b;
      o.dvsr    = s.neg ? {s.root_a[62:0], 1'b0} : s.root_b;
      o.rem     = ua >> (64 - FRAC_BITS);
      o.lo      = ua << FRAC_BITS;
      o.q       = '0;
      o.ovr     = 1'b0;
      o.ovr_val = '0;
      if (o.dvsr == '0) begin
         o.ovr     = 1'b1;
         o.ovr_val = (ua == '0) ? 64'd0 : mlin_pkg::SMAX;
      end else if (o.rem >= o.dvsr) begin
         o.ovr     = 1'b1;
         o.ovr_val = mlin_pkg::SMAX;
      end
      return o;
   endfunction

   function automatic dv_type dv_step(dv_type s);
      dv_type      o;
      logic [64:0] w;
      o = s;
      w = {s.rem, s.lo[63]};
      if (w >= {1'b0, s.dvsr}) begin
         w   = w - {1'b0, s.dvsr};
         o.q = {s.q[62:0], 1'b1};
      end else begin
         o.q = {s.q[62:0], 1'b0};
      end
      o.rem = w[63:0];
      o.lo  = s.lo << 1;
      return o;
   endfunction

   always_comb begin
      sq_init        = '0;
      sq_init.rad_a  = {64'd0, rad_a} << FRAC_BITS;
      sq_init.rad_b  = {64'd0, rad_b} << FRAC_BITS;
      sq_init.gam    = gam;
      sq_init.neg    = neg;
   end

   always_ff @(posedge clock) begin
      sq_ff[0] <= sq_step(sq_init);
      for (int i = 1; i < mlin_pkg::SQRT_STEPS; i++) begin
         sq_ff[i] <= sq_step(sq_ff[i-1]);
      end
      dv0_ff   <= dv_prep(sq_ff[mlin_pkg::SQRT_STEPS-1]);
      dv_ff[0] <= dv_step(dv0_ff);
      for (int i = 1; i < mlin_pkg::DIV_STEPS; i++) begin
         dv_ff[i] <= dv_step(dv_ff[i-1]);
      end
      sa_ff <= dv_ff[mlin_pkg::DIV_STEPS-1].sa;
      s2_ff <= dv_ff[mlin_pkg::DIV_STEPS-1].s2;
      if (dv_ff[mlin_pkg::DIV_STEPS-1].ovr) begin
         q_ff <= dv_ff[mlin_pkg::DIV_STEPS-1].ovr_val;
      end else if (dv_ff[mlin_pkg::DIV_STEPS-1].q[63]) begin
         q_ff <= mlin_pkg::SMAX;
      end else begin
         q_ff <= dv_ff[mlin_pkg::DIV_STEPS-1].q;
      end
   end

   assign sa   = sa_ff;
   assign s2   = s2_ff;
   assign quot = q_ff;

endmodule

### src/mosfet_level1_linearize_top.sv
// ============================================================================
// mosfet_level1_linearize_top
// level-1 mosfet evaluation at one bias point: threshold with three-piece
// body effect, then id, gm, gds and gmb in signed fixed point, saturating
// ============================================================================
//
//  channel  ports                          direction  handshake
//  -------  -----------------------------  ---------  ---------------------------
//  request  start, busy, req_*             in         taken when start && !busy
//  result   rsp_valid, rsp_*               out        one-cycle strobe, no stall
//  csr      csr_valid, csr_ready, csr_*    in         written when valid && ready
//
//  one request per cycle while busy is low; each result passes through the
//  64-stage square root, the 64-stage divider and four multiply levels
//  synchronous reset clears valid bits and csr registers (phi resets to one);
//  busy is high for the cycle after reset
//  the receiver cannot stall, so the pipeline never holds; csr_ready is
//  always high and csr writes are meant for an empty pipeline
//
module mosfet_level1_linearize_top #(
   parameter int FRAC_BITS = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mlin_pkg::word_type req_gate_source_voltage,
   input  mlin_pkg::word_type req_drain_source_voltage,
   input  mlin_pkg::word_type req_bulk_source_voltage,
   output logic               rsp_valid,
   output mlin_pkg::word_type rsp_drain_current,
   output mlin_pkg::word_type rsp_transconductance,
   output mlin_pkg::word_type rsp_output_conductance,
   output mlin_pkg::word_type rsp_body_transconductance,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int QL      = mlin_pkg::QMUL_LAT;
   localparam int RSP_LAT = mlin_pkg::BODY_LAT + 4 * QL + 7;
   localparam mlin_pkg::word_type Q_ONE = mlin_pkg::word_type'(64'd1 << FRAC_BITS);
   // conductance floor of 1e-12, rounded to nearest
   localparam mlin_pkg::word_type GFLOOR =
      ((64'd1 << FRAC_BITS) + 64'd500000000000) / 64'd1000000000000;

   // everything an item carries down the pipe
   typedef struct packed {
      logic vld;
      logic neg;
      logic mid;
      logic cutoff;
      logic triode;
      mlin_pkg::word_type vgs, vds, vbs, xa, dvth, vth, clm, vv2, kv;
      mlin_pkg::word_type vov, vmd, q, a2, a3, a4, a5, b3, x, gm;
   } ctx_type;

   // csr registers
   mlin_pkg::word_type vt0_ff;
   logic [62:0] gam_ff, phi_ff, kp_ff, lam_ff;
   mlin_pkg::word_type gam_w, kp_w, lam_w, two_phi, four_phi;
   logic busy_ff;
   logic accept;

   ctx_type e_in, e_ff;
   ctx_type d0_ff [mlin_pkg::BODY_LAT];
   ctx_type d1_ff [QL];
   ctx_type d2_ff [QL];
   ctx_type d3_ff [QL];
   ctx_type d4_ff [QL];
   ctx_type c0, c0n, c1, c2, c3, c4;
   ctx_type r1_in, r1_ff, r2_in, r2_ff, r3_in, r3_ff, r4_in, r4_ff, r5_in, r5_ff;

   mlin_pkg::word_type b_sa, b_s2, b_q;
   mlin_pkg::word_type m1a, m1b;
   mlin_pkg::word_type p_vth, p_lv, p_vv, p_kv;
   mlin_pkg::word_type p_a1, p_a2, p_a3, p_a4, p_a5;
   mlin_pkg::word_type p_b1, p_b2, p_b3, p_b4;
   mlin_pkg::word_type p_c1, p_c2, p_c3;
   mlin_pkg::word_type t_lam;

   logic               o_vld_ff, o_cut_ff;
   mlin_pkg::word_type o_id_ff, o_gm_ff, o_gds_ff, o_gmb_ff;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vt0_ff <= '0;
         gam_ff <= '0;
         phi_ff <= 63'(64'd1 << FRAC_BITS);
         kp_ff  <= '0;
         lam_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mlin_pkg::REG_VT0:    vt0_ff <= csr_wdata;
            mlin_pkg::REG_GAMMA:  gam_ff <= csr_wdata[62:0];
            mlin_pkg::REG_PHI:    phi_ff <= csr_wdata[62:0];
            mlin_pkg::REG_KP:     kp_ff  <= csr_wdata[62:0];
            mlin_pkg::REG_LAMBDA: lam_ff <= csr_wdata[62:0];
            default: ;
         endcase
      end
   end

   assign gam_w    = {1'b0, gam_ff};
   assign kp_w     = {1'b0, kp_ff};
   assign lam_w    = {1'b0, lam_ff};
   // 2*phi and 4*phi clip to the largest positive value
   assign two_phi  = phi_ff[62] ? mlin_pkg::SMAX : {phi_ff, 1'b0};
   assign four_phi = (phi_ff[62] || phi_ff[61]) ? mlin_pkg::SMAX : {phi_ff[61:0], 2'b00};

   // ---------------------------------------------------------------- intake
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy;

   // region of the body bias and radicand of the square-root law
   always_comb begin
      e_in     = '0;
      e_in.vld = accept;
      e_in.vgs = req_gate_source_voltage;
      e_in.vds = req_drain_source_voltage;
      e_in.vbs = req_bulk_source_voltage;
      e_in.neg = (req_bulk_source_voltage <= 0);
      e_in.mid = !e_in.neg && (req_bulk_source_voltage <= four_phi);
      e_in.xa  = e_in.neg ? mlin_pkg::sat_sub(two_phi, req_bulk_source_voltage) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff.vld <= 1'b0;
      end else begin
         e_ff <= e_in;
      end
   end

   // ---------------------------------------------------------------- body effect
   // sqrt(2*phi - vbs), sqrt(2*phi) and gamma over (2*sa or s2)
   mlin_body #(.FRAC_BITS(FRAC_BITS)) u_body (
      .clock (clock),
      .rad_a (e_ff.xa),
      .rad_b (two_phi),
      .gam   (gam_ff),
      .neg   (e_ff.neg),
      .sa    (b_sa),
      .s2    (b_s2),
      .quot  (b_q)
   );

   // item context rides alongside the body unit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlin_pkg::BODY_LAT; i++) d0_ff[i].vld <= 1'b0;
      end else begin
         d0_ff[0] <= e_ff;
         for (int i = 1; i < mlin_pkg::BODY_LAT; i++) begin
            d0_ff[i] <= d0_ff[i-1];
         end
      end
   end

   assign c0 = d0_ff[mlin_pkg::BODY_LAT-1];

   // ---------------------------------------------------------------- level 1
   // threshold term, lambda*|vds|, vds^2 and k*vds
   always_comb begin
      m1a = c0.mid ? b_q : gam_w;
      if (c0.neg) begin
         m1b = b_sa - b_s2;
      end else if (c0.mid) begin
         m1b = c0.vbs;
      end else begin
         m1b = b_s2;
      end
      c0n      = c0;
      c0n.dvth = (c0.neg || c0.mid) ? -b_q : '0;
   end

   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_vth (.clock(clock), .a(m1a), .b(m1b), .p(p_vth));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_lv  (.clock(clock), .a(lam_w),
      .b(mlin_pkg::mag_sat(c0.vds)), .p(p_lv));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_vv  (.clock(clock), .a(c0.vds), .b(c0.vds), .p(p_vv));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_kv  (.clock(clock), .a(kp_w), .b(c0.vds), .p(p_kv));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QL; i++) d1_ff[i].vld <= 1'b0;
      end else begin
         d1_ff[0] <= c0n;
         for (int i = 1; i < QL; i++) d1_ff[i] <= d1_ff[i-1];
      end
   end

   assign c1 = d1_ff[QL-1];

   always_comb begin
      r1_in     = c1;
      r1_in.vth = c1.neg ? mlin_pkg::sat_add(vt0_ff, p_vth) : mlin_pkg::sat_sub(vt0_ff, p_vth);
      r1_in.clm = mlin_pkg::sat_add(Q_ONE, p_lv);
      r1_in.vv2 = mlin_pkg::half(p_vv);
      r1_in.kv  = p_kv;
   end

   // overdrive, then region flags
   always_comb begin
      r2_in        = r1_ff;
      r2_in.vov    = mlin_pkg::sat_sub(r1_ff.vgs, r1_ff.vth);
      r2_in.cutoff = (r1_ff.vgs < r1_ff.vth);
   end

   always_comb begin
      r3_in        = r2_ff;
      r3_in.vmd    = mlin_pkg::sat_sub(r2_ff.vov, r2_ff.vds);
      r3_in.triode = (r2_ff.vds < r2_ff.vov);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_ff.vld <= 1'b0;
         r2_ff.vld <= 1'b0;
         r3_ff.vld <= 1'b0;
      end else begin
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         r3_ff <= r3_in;
      end
   end

   // ---------------------------------------------------------------- level 2
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_a1 (.clock(clock), .a(r3_ff.vov), .b(r3_ff.vds),
      .p(p_a1));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_a2 (.clock(clock), .a(r3_ff.vov), .b(r3_ff.vov),
      .p(p_a2));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_a3 (.clock(clock), .a(kp_w), .b(r3_ff.vmd), .p(p_a3));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_a4 (.clock(clock), .a(kp_w), .b(r3_ff.vov), .p(p_a4));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_a5 (.clock(clock), .a(r3_ff.kv), .b(r3_ff.clm),
      .p(p_a5));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QL; i++) d2_ff[i].vld <= 1'b0;
      end else begin
         d2_ff[0] <= r3_ff;
         for (int i = 1; i < QL; i++) d2_ff[i] <= d2_ff[i-1];
      end
   end

   assign c2 = d2_ff[QL-1];

   always_comb begin
      r4_in    = c2;
      r4_in.q  = mlin_pkg::sat_sub(p_a1, c2.vv2);
      r4_in.a2 = p_a2;
      r4_in.a3 = p_a3;
      r4_in.a4 = p_a4;
      r4_in.a5 = p_a5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r4_ff.vld <= 1'b0;
      end else begin
         r4_ff <= r4_in;
      end
   end

   // ---------------------------------------------------------------- level 3
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_b1 (.clock(clock), .a(kp_w), .b(r4_ff.q), .p(p_b1));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_b2 (.clock(clock), .a(kp_w), .b(r4_ff.a2), .p(p_b2));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_b3 (.clock(clock), .a(r4_ff.a3), .b(r4_ff.clm),
      .p(p_b3));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_b4 (.clock(clock), .a(r4_ff.a4), .b(r4_ff.clm),
      .p(p_b4));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QL; i++) d3_ff[i].vld <= 1'b0;
      end else begin
         d3_ff[0] <= r4_ff;
         for (int i = 1; i < QL; i++) d3_ff[i] <= d3_ff[i-1];
      end
   end

   assign c3 = d3_ff[QL-1];

   // x is k*q in triode and h = k*vov^2/2 in saturation
   always_comb begin
      r5_in    = c3;
      r5_in.x  = c3.triode ? p_b1 : mlin_pkg::half(p_b2);
      r5_in.b3 = p_b3;
      if (c3.cutoff) begin
         r5_in.gm = GFLOOR;
      end else if (c3.triode) begin
         r5_in.gm = c3.a5;
      end else begin
         r5_in.gm = p_b4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r5_ff.vld <= 1'b0;
      end else begin
         r5_ff <= r5_in;
      end
   end

   // ---------------------------------------------------------------- level 4
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_c1 (.clock(clock), .a(r5_ff.x), .b(lam_w), .p(p_c1));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_c2 (.clock(clock), .a(r5_ff.x), .b(r5_ff.clm),
      .p(p_c2));
   mlin_qmul #(.FRAC_BITS(FRAC_BITS)) u_c3 (.clock(clock), .a(r5_ff.gm), .b(r5_ff.dvth),
      .p(p_c3));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QL; i++) d4_ff[i].vld <= 1'b0;
      end else begin
         d4_ff[0] <= r5_ff;
         for (int i = 1; i < QL; i++) d4_ff[i] <= d4_ff[i-1];
      end
   end

   assign c4 = d4_ff[QL-1];

   // lambda term takes the sign of vds
   always_comb begin
      if (c4.vds[63]) begin
         t_lam = mlin_pkg::sat_neg(p_c1);
      end else if (c4.vds == '0) begin
         t_lam = '0;
      end else begin
         t_lam = p_c1;
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= c4.vld;
         o_cut_ff <= c4.cutoff;
         o_id_ff  <= c4.cutoff ? '0 : p_c2;
         o_gm_ff  <= c4.gm;
         if (c4.cutoff) begin
            o_gds_ff <= GFLOOR;
         end else if (c4.triode) begin
            o_gds_ff <= mlin_pkg::sat_add(t_lam, c4.b3);
         end else begin
            o_gds_ff <= t_lam;
         end
         o_gmb_ff <= mlin_pkg::sat_neg(p_c3);
      end
   end

   assign rsp_valid                 = o_vld_ff;
   assign rsp_drain_current         = o_id_ff;
   assign rsp_transconductance      = o_gm_ff;
   assign rsp_output_conductance    = o_gds_ff;
   assign rsp_body_transconductance = o_gmb_ff;

   // ---------------------------------------------------------------- checks
   // every request comes out after the fixed latency
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LAT rsp_valid)
      else $error("request lost in pipeline");

   // no result without a request at the matching time
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, RSP_LAT))
      else $error("result without request");

   // cutoff gives zero current and floored conductances
   a_cutoff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && o_cut_ff) |-> (rsp_drain_current == '0 &&
         rsp_transconductance == GFLOOR && rsp_output_conductance == GFLOOR))
      else $error("cutoff outputs wrong");

endmodule

### test/tb_mosfet_level1_linearize_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_mosfet_level1_linearize_top
// Self-checking bench for the level-1 mosfet linearizer. Requests carry a
// Vgs/Vds/Vbs bias point. An in-bench fixed-point model works out the
// expected id, gm, gds and gmb for each request and checks every result in
// order. Several register settings are used, the extremes among them, and
// the sender idles at different rates.
// ============================================================================
module tb_mosfet_level1_linearize_top;

   localparam int FRAC      = 48;
   localparam int WDOG_MAX  = 5000;
   localparam int DRAIN_LAT = 200;

   typedef struct packed {
      mlin_pkg::word_type id;
      mlin_pkg::word_type gm;
      mlin_pkg::word_type gds;
      mlin_pkg::word_type gmb;
   } bias_result_type;

   // small scoreboard: holds the register copy, predicts and checks
   class mos_scoreboard;
      localparam mlin_pkg::word_type MAXV     = {1'b0, {63{1'b1}}};
      localparam mlin_pkg::word_type MINV     = {1'b1, {63{1'b0}}};
      localparam mlin_pkg::word_type Q_UNIT   = mlin_pkg::word_type'(64'd1 << FRAC);
      localparam mlin_pkg::word_type GM_FLOOR =
         mlin_pkg::word_type'(((64'd1 << FRAC) + 64'd500000000000) / 64'd1000000000000);

      mlin_pkg::word_type vt0;
      logic [62:0]        gamma, phi, kgain, lambda;
      bias_result_type    expected_q[$];
      int                 errors;

      function new();
         vt0 = 0; gamma = 0; kgain = 0; lambda = 0;
         phi = 63'd1 << FRAC;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            mlin_pkg::REG_VT0:    vt0    = val;
            mlin_pkg::REG_GAMMA:  gamma  = val[62:0];
            mlin_pkg::REG_PHI:    phi    = val[62:0];
            mlin_pkg::REG_KP:     kgain  = val[62:0];
            mlin_pkg::REG_LAMBDA: lambda = val[62:0];
            default: ;
         endcase
      endfunction

      function mlin_pkg::word_type clip_add(mlin_pkg::word_type a, mlin_pkg::word_type b);
         logic signed [64:0] w;
         w = {a[63], a} + {b[63], b};
         if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MAXV;
         if (w < -65'sh0_8000_0000_0000_0000) return MINV;
         return w[63:0];
      endfunction

      function mlin_pkg::word_type clip_sub(mlin_pkg::word_type a, mlin_pkg::word_type b);
         logic signed [64:0] w;
         w = {a[63], a} - {b[63], b};
         if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MAXV;
         if (w < -65'sh0_8000_0000_0000_0000) return MINV;
         return w[63:0];
      endfunction

      function mlin_pkg::word_type clip_neg(mlin_pkg::word_type a);
         return (a == MINV) ? MAXV : -a;
      endfunction

      function logic [63:0] abs_mag(mlin_pkg::word_type a);
         return a[63] ? (64'd0 - a) : a;
      endfunction

      function mlin_pkg::word_type signed_out(logic neg, logic big, logic [63:0] m);
         if (neg) begin
            if (big || m[63]) return MINV;
            return -m;
         end
         if (big || m[63]) return MAXV;
         return m;
      endfunction

      // product, magnitude truncated toward zero
      function mlin_pkg::word_type fx_mul(mlin_pkg::word_type a, mlin_pkg::word_type b);
         logic [127:0] p;
         p = {64'd0, abs_mag(a)} * {64'd0, abs_mag(b)};
         p = p >> FRAC;
         return signed_out(a[63] ^ b[63], p[127:64] != 0, p[63:0]);
      endfunction

      // quotient of two non-negative values
      function mlin_pkg::word_type fx_div(mlin_pkg::word_type a, mlin_pkg::word_type b);
         logic [127:0] q;
         logic [63:0]  ua, ub;
         ua = a;
         ub = b;
         if (ub == 0) return (ua == 0) ? mlin_pkg::word_type'(0) : MAXV;
         if ((ua >> (64 - FRAC)) >= ub) return MAXV;
         q = ({64'd0, ua} << FRAC) / {64'd0, ub};
         return signed_out(1'b0, 1'b0, q[63:0]);
      endfunction

      // floored root of x scaled by the fraction
      function mlin_pkg::word_type fx_sqrt(mlin_pkg::word_type x);
         logic [127:0] n;
         logic [63:0]  r, c;
         n = {64'd0, x} << FRAC;
         r = 0;
         for (int b = 61; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
         end
         return r;
      endfunction

      function void note(mlin_pkg::word_type vgs, mlin_pkg::word_type vds,
                         mlin_pkg::word_type vbs);
         mlin_pkg::word_type two_phi, four_phi, s2, sa, m, vth, dvth, vov, clm;
         mlin_pkg::word_type gam, kk, lam, q, kq, t, h;
         bias_result_type r;
         gam = {1'b0, gamma};
         kk  = {1'b0, kgain};
         lam = {1'b0, lambda};
         two_phi  = ({1'b0, phi} > 64'h3FFF_FFFF_FFFF_FFFF) ? MAXV : {phi, 1'b0};
         four_phi = ({1'b0, phi} > 64'h1FFF_FFFF_FFFF_FFFF) ? MAXV : {phi[61:0], 2'b00};
         s2 = fx_sqrt(two_phi);
         // three-piece body effect
         if (vbs <= 0) begin
            sa   = fx_sqrt(clip_sub(two_phi, vbs));
            vth  = clip_add(vt0, fx_mul(gam, sa - s2));
            dvth = -fx_div(gam, 2 * sa);
         end else if (vbs <= four_phi) begin
            m    = fx_div(gam, s2);
            vth  = clip_sub(vt0, fx_mul(m, vbs));
            dvth = -m;
         end else begin
            vth  = clip_sub(vt0, fx_mul(gam, s2));
            dvth = 0;
         end
         vov = clip_sub(vgs, vth);
         clm = clip_add(Q_UNIT, fx_mul(lam, signed_out(1'b0, 1'b0, abs_mag(vds))));
         if (vgs < vth) begin
            r.id  = 0;
            r.gm  = GM_FLOOR;
            r.gds = GM_FLOOR;
         end else if (vds < vov) begin
            // triode
            q  = fx_mul(vds, vds);
            q  = clip_sub(fx_mul(vov, vds), q / 2);
            kq = fx_mul(kk, q);
            t  = fx_mul(kq, lam);
            if (vds < 0) t = clip_neg(t);
            else if (vds == 0) t = 0;
            r.id  = fx_mul(kq, clm);
            r.gm  = fx_mul(fx_mul(kk, vds), clm);
            r.gds = clip_add(t, fx_mul(fx_mul(kk, clip_sub(vov, vds)), clm));
         end else begin
            // saturation
            h = fx_mul(kk, fx_mul(vov, vov));
            h = h / 2;
            t = fx_mul(h, lam);
            if (vds < 0) t = clip_neg(t);
            else if (vds == 0) t = 0;
            r.id  = fx_mul(h, clm);
            r.gm  = fx_mul(fx_mul(kk, vov), clm);
            r.gds = t;
         end
         r.gmb = clip_neg(fx_mul(r.gm, dvth));
         expected_q.push_back(r);
      endfunction

      function void check(bias_result_type got);
         bias_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result id=%h gm=%h gds=%h gmb=%h",
                                       got.id, got.gm, got.gds, got.gmb);
            return;
         end
         e = expected_q.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp id=%h gm=%h gds=%h gmb=%h", e.id, e.gm, e.gds, e.gmb);
               $display("         got id=%h gm=%h gds=%h gmb=%h",
                        got.id, got.gm, got.gds, got.gmb);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock, reset;
   logic               start, busy;
   mlin_pkg::word_type req_vgs, req_vds, req_vbs;
   logic               rsp_valid;
   mlin_pkg::word_type rsp_id, rsp_gm, rsp_gds, rsp_gmb;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [63:0]        csr_wdata;

   mos_scoreboard sb;
   int            idle_pct;
   int            wdog;

   // typical device values in Q16.48
   localparam mlin_pkg::word_type VT0_TYP   = 64'sd197032483697459;  // 0.7 V
   localparam mlin_pkg::word_type GAMMA_TYP = 64'sd112589990684262;  // 0.4 sqrt(V)
   localparam mlin_pkg::word_type PHI_TYP   = 64'sd168884986026394;  // 0.6 V
   localparam mlin_pkg::word_type K_TYP     = 64'sd562949953421;     // 2 mA/V^2
   localparam mlin_pkg::word_type LAM_TYP   = 64'sd5629499534213;    // 0.02 1/V
   localparam mlin_pkg::word_type ONE_V     = 64'sd281474976710656;

   mosfet_level1_linearize_top u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_gate_source_voltage   (req_vgs),
      .req_drain_source_voltage  (req_vds),
      .req_bulk_source_voltage   (req_vbs),
      .rsp_valid                 (rsp_valid),
      .rsp_drain_current         (rsp_id),
      .rsp_transconductance      (rsp_gm),
      .rsp_output_conductance    (rsp_gds),
      .rsp_body_transconductance (rsp_gmb),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note(req_vgs, req_vds, req_vbs);
         if (rsp_valid) sb.check({rsp_id, rsp_gm, rsp_gds, rsp_gmb});
      end
   end

   // watchdog: cycles with no request, result or csr write taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         wdog <= 0;
      end else begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // one request; start stays high across back-to-back requests
   task automatic send_bias(mlin_pkg::word_type vgs, mlin_pkg::word_type vds,
                            mlin_pkg::word_type vbs);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start   <= 1'b1;
      req_vgs <= vgs;
      req_vds <= vds;
      req_vbs <= vbs;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // pipeline must be empty before any csr write
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_device(mlin_pkg::word_type vt0, mlin_pkg::word_type gam,
                              mlin_pkg::word_type phi, mlin_pkg::word_type kk,
                              mlin_pkg::word_type lam);
      drain_results();
      write_csr(mlin_pkg::REG_VT0, vt0);
      write_csr(mlin_pkg::REG_GAMMA, gam);
      write_csr(mlin_pkg::REG_PHI, phi);
      write_csr(mlin_pkg::REG_KP, kk);
      write_csr(mlin_pkg::REG_LAMBDA, lam);
   endtask

   // mostly a few volts, sometimes rails or full-range noise
   function automatic mlin_pkg::word_type rand_volt();
      mlin_pkg::word_type v;
      int                 sel;
      v   = {$urandom, $urandom};
      sel = $urandom_range(99);
      if (sel < 75) return v >>> (13 + $urandom_range(0, 8));
      if (sel < 80) return mos_scoreboard::MAXV;
      if (sel < 85) return mos_scoreboard::MINV;
      if (sel < 88) return 0;
      return v;
   endfunction

   function automatic logic [63:0] rand_param();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v >> (1 + $urandom_range(0, 14));
   endfunction

   task automatic random_burst(int count, int pct);
      idle_pct = pct;
      repeat (count) begin
         // occasional stretch with no gaps
         if ($urandom_range(99) < 3) idle_pct = 0;
         else if ($urandom_range(99) < 3) idle_pct = pct;
         send_bias(rand_volt(), rand_volt(), rand_volt());
      end
   endtask

   initial begin
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_vgs   = '0;
      req_vds   = '0;
      req_vbs   = '0;
      csr_valid = 1'b0;
      csr_index = mlin_pkg::REG_VT0;
      csr_wdata = '0;
      idle_pct  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values
      send_bias(ONE_V, ONE_V, 0);
      send_bias(mos_scoreboard::MINV, mos_scoreboard::MINV, mos_scoreboard::MINV);
      send_bias(mos_scoreboard::MAXV, mos_scoreboard::MAXV, mos_scoreboard::MAXV);

      // directed: each region and each body-effect piece at a typical device
      load_device(VT0_TYP, GAMMA_TYP, PHI_TYP, K_TYP, LAM_TYP);
      send_bias(0, ONE_V, 0);                                  // cutoff
      send_bias(0, ONE_V, -ONE_V);                             // cutoff, deep body
      send_bias(3 * ONE_V, ONE_V / 2, 0);                      // triode
      send_bias(3 * ONE_V, -ONE_V, 0);                         // triode, negative vds
      send_bias(3 * ONE_V, 0, 0);                              // triode, zero vds
      send_bias(2 * ONE_V, 4 * ONE_V, 0);                      // saturation
      send_bias(2 * ONE_V, 4 * ONE_V, ONE_V / 2);              // linear body law
      send_bias(2 * ONE_V, 4 * ONE_V, PHI_TYP * 4);            // top of linear law
      send_bias(2 * ONE_V, 4 * ONE_V, PHI_TYP * 4 + 1);        // flat body law
      send_bias(2 * ONE_V, 4 * ONE_V, 1);
      send_bias(2 * ONE_V, 4 * ONE_V, -1);
      send_bias(VT0_TYP, ONE_V, 0);                            // vgs at threshold
      send_bias(mos_scoreboard::MAXV, mos_scoreboard::MAXV, 0);
      send_bias(mos_scoreboard::MAXV, mos_scoreboard::MINV, 0);
      send_bias(mos_scoreboard::MINV, mos_scoreboard::MAXV, mos_scoreboard::MAXV);
      send_bias(mos_scoreboard::MAXV, ONE_V, mos_scoreboard::MINV);
      send_bias(-1, -1, -1);
      random_burst(180, 0);

      // all registers at their upper extremes, but vt0 at its lowest
      load_device(mos_scoreboard::MINV, mos_scoreboard::MAXV, mos_scoreboard::MAXV,
                  mos_scoreboard::MAXV, mos_scoreboard::MAXV);
      random_burst(80, 62);

      // lower extremes: smallest nonzero phi, no body effect, no gain; vt0 at its highest
      load_device(mos_scoreboard::MAXV, 0, 1, 0, 0);
      random_burst(50, 35);

      // random device
      load_device(rand_param() | 64'h8000_0000_0000_0000 & {64{1'($urandom_range(1))}},
                  rand_param(), rand_param() | 64'd1, rand_param(), rand_param());
      random_burst(160, 62);

      // back to a typical device with heavy traffic
      load_device(VT0_TYP, GAMMA_TYP, PHI_TYP, K_TYP, LAM_TYP);
      random_burst(160, 0);

      drain_results();
      repeat (DRAIN_LAT) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
